>>> design/spiq_pkg.sv
// shared types and codes for the sorted insert priority queue
package spiq_pkg;

  localparam int KEY_W = 16;
  localparam int PLD_W = 16;
  localparam int CNT_OUT_W = 7;

  // command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PLD_W-1:0] payload;
  } entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    logic   desc;
    entry_t new_e;
  } cell_ctl_t;

endpackage

>>> design/spiq_cell.sv
// one slot of the sorted row: holds an entry, shifts back on insert, forward on pop
module spiq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic               clk,
  input  spiq_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      count,
  input  logic               prev_ge,
  input  spiq_pkg::entry_t   prev_e,
  input  spiq_pkg::entry_t   next_e,
  output logic               ge,
  output spiq_pkg::entry_t   e_q,
  output spiq_pkg::entry_t   e_nxt
);
  import spiq_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  entry_t e_r;
  logic   held_first;
  logic   new_first;

  // held key ranks strictly before the new key
  assign held_first = ctl.desc ? (e_r.key > ctl.new_e.key) : (e_r.key < ctl.new_e.key);
  // new key ranks strictly before the held key
  assign new_first  = ctl.desc ? (ctl.new_e.key > e_r.key) : (ctl.new_e.key < e_r.key);

  // ge: insert position is at or before this slot
  always_comb begin
    if (IDX == 0) begin
      ge = (count == '0) || new_first;
    end else begin
      ge = prev_ge || (count <= IDX_C) || !held_first;
    end
  end

  always_comb begin
    e_nxt = e_r;
    if (ctl.pop_en) begin
      e_nxt = next_e;
    end else if (ctl.push_en) begin
      if (prev_ge) begin
        e_nxt = prev_e;
      end else if (ge) begin
        e_nxt = ctl.new_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

  assign e_q = e_r;

endmodule

>>> design/sorted_insert_priority_queue.sv
// sorted insert priority queue: top level with the cell row and result register
// each result word is registered and appears in the cycle after its command word is accepted
// throughput: one command per cycle, push, pop and clear alike, while out_stall is low
// every cell compares and shifts in the same cycle, so the rate does not depend on the depth
// reset clears the entry count, the order bit and the result valid; cell contents are not reset
module sorted_insert_priority_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_key,
  input  logic [15:0] in_payload,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_popped_key,
  output logic [15:0] out_popped_payload,
  output logic        out_head_valid,
  output logic [15:0] out_head_key,
  output logic [15:0] out_head_payload,
  output logic [6:0]  out_entry_count
);
  import spiq_pkg::*;

  // count must reach the depth itself
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // order register
  logic desc_r;

  // occupancy
  logic [CW-1:0] count_r, count_nxt;

  // handshake
  logic accept;
  logic push_ok, pop_ok;

  // cell row wiring; ge_chain[i] feeds cell i, cell i drives ge_chain[i+1]
  cell_ctl_t ctl;
  logic      ge_chain [QUEUE_DEPTH+1];
  entry_t    e_q      [QUEUE_DEPTH];
  entry_t    e_nxt    [QUEUE_DEPTH];

  // result register
  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  entry_t        popped_r, popped_nxt;
  logic          head_valid_r;
  entry_t        head_r, head_nxt;
  logic [CW-1:0] count_out_r;
  logic [CW+CNT_OUT_W-1:0] count_ext;

  // a new word may enter whenever the result register is free or being drained
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign push_ok = accept && (in_command == CMD_PUSH) && (count_r != DEPTH_C);
  assign pop_ok  = accept && (in_command == CMD_POP) && (count_r != '0);

  always_comb begin
    ctl.push_en       = push_ok;
    ctl.pop_en        = pop_ok;
    ctl.desc          = desc_r;
    ctl.new_e.key     = in_key;
    ctl.new_e.payload = in_payload;
  end

  // nothing ranks ahead of the head
  assign ge_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;

    // head takes nothing from behind; the tail refills from itself on pop
    if (i == 0) begin : g_head
      assign prev_e = ctl.new_e;
    end else begin : g_mid
      assign prev_e = e_q[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = e_q[i];
    end else begin : g_body
      assign next_e = e_q[i+1];
    end

    spiq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .count   (count_r),
      .prev_ge (ge_chain[i]),
      .prev_e  (prev_e),
      .next_e  (next_e),
      .ge      (ge_chain[i+1]),
      .e_q     (e_q[i]),
      .e_nxt   (e_nxt[i])
    );
  end

  // occupancy and status for this word
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (accept) begin
      case (in_command)
        CMD_PUSH: begin
          if (count_r == DEPTH_C) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // popped entry is the head before the shift, peek is the head after it
  always_comb begin
    popped_nxt = '0;
    if (pop_ok) begin
      popped_nxt = e_q[0];
    end
    head_nxt = '0;
    if (count_nxt != '0) begin
      head_nxt = e_nxt[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      popped_r     <= popped_nxt;
      head_valid_r <= (count_nxt != '0);
      head_r       <= head_nxt;
      count_out_r  <= count_nxt;
    end
  end

  // count port carries the low bits of the occupancy
  assign count_ext = {{CNT_OUT_W{1'b0}}, count_out_r};

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_popped_key     = popped_r.key;
  assign out_popped_payload = popped_r.payload;
  assign out_head_valid     = head_valid_r;
  assign out_head_key       = head_r.key;
  assign out_head_payload   = head_r.payload;
  assign out_entry_count    = count_ext[CNT_OUT_W-1:0];

endmodule

>>> design/spiq_chk.sv
// port-level checker for the sorted insert priority queue, bound to the top level
module spiq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [15:0] out_popped_key,
  input logic [15:0] out_popped_payload,
  input logic        out_head_valid
);
  import spiq_pkg::*;

  // the command side only backs up behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall raised with no result waiting");

  // every accepted word yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word produced no result");

  // a drained result with nothing new behind it leaves the port empty
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !(in_valid && !in_stall)) |=> !out_valid)
    else $error("result shown with no word accepted");

  // a refused push means the queue was full, a refused pop means it was empty
  a_refusal_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_head_valid)
    else $error("push refused while queue not full");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |->
      (!out_head_valid && out_popped_key == 16'd0 && out_popped_payload == 16'd0))
    else $error("pop refused but queue shows entries");

endmodule

bind sorted_insert_priority_queue spiq_chk u_spiq_chk (.*);

>>> bench/tb_sorted_insert_priority_queue.sv
// self-checking testbench for the sorted insert priority queue
`timescale 1ns / 1ps

module tb_sorted_insert_priority_queue;
  import spiq_pkg::*;

  localparam int QUEUE_DEPTH = 64;

  // command code 3 has no name in the package: the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // command mix of one random burst
  localparam int BURST_FILL  = 0;
  localparam int BURST_DRAIN = 1;
  localparam int BURST_MIX   = 2;

  // key spread of one random burst
  localparam int KEYS_NARROW = 0;
  localparam int KEYS_ANY    = 1;
  localparam int KEYS_CORNER = 2;

  // receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 300;

  // one result word, field by field
  typedef struct packed {
    logic [1:0]           status;
    logic [KEY_W-1:0]     popped_key;
    logic [PLD_W-1:0]     popped_payload;
    logic                 head_valid;
    logic [KEY_W-1:0]     head_key;
    logic [PLD_W-1:0]     head_payload;
    logic [CNT_OUT_W-1:0] entry_count;
  } result_t;

  // one directed command word; fixed says the result is spelled out in res
  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [PLD_W-1:0] payload;
    logic             fixed;
    result_t          res;
  } stim_row_t;

  // directed words, walked in order with ascending order selected
  localparam int DIR_ROWS = 19;
  localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // pop, clear and the unused code on an empty queue
    '{CMD_POP,    16'h0000, 16'h0000, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0}},
    '{CMD_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_DONE, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0}},
    '{CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_DONE, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0}},
    // largest key first, then the smallest takes the head
    '{CMD_PUSH, 16'hFFFF, 16'h0000, 1'b1, '{ST_DONE, 16'h0, 16'h0, 1'b1, 16'hFFFF, 16'h0000, 7'd1}},
    '{CMD_PUSH, 16'h0000, 16'hFFFF, 1'b1, '{ST_DONE, 16'h0, 16'h0, 1'b1, 16'h0000, 16'hFFFF, 7'd2}},
    // tie with the head goes behind it
    '{CMD_PUSH, 16'h0000, 16'h1111, 1'b1, '{ST_DONE, 16'h0, 16'h0, 1'b1, 16'h0000, 16'hFFFF, 7'd3}},
    // second tie lands right behind the head, ahead of the earlier tie
    '{CMD_PUSH,   16'h0000, 16'h2222, 1'b0, '0},
    '{CMD_PUSH,   16'h8000, 16'hA5A5, 1'b0, '0},
    '{CMD_PUSH,   16'h7FFF, 16'h5A5A, 1'b0, '0},
    '{CMD_UNUSED, 16'h1234, 16'h5678, 1'b0, '0},
    '{CMD_POP,    16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{CMD_POP,    16'h0000, 16'h0000, 1'b0, '0},
    '{CMD_POP,    16'h0000, 16'h0000, 1'b0, '0},
    '{CMD_PUSH,   16'h0001, 16'h0001, 1'b0, '0},
    '{CMD_POP,    16'h0000, 16'h0000, 1'b0, '0},
    // clear with entries left, then refuse a pop
    '{CMD_CLEAR, 16'h0000, 16'h0000, 1'b1, '{ST_DONE, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0}},
    '{CMD_POP,   16'h0000, 16'h0000, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0}},
    '{CMD_PUSH,  16'h5555, 16'hAAAA, 1'b1, '{ST_DONE, 16'h0, 16'h0, 1'b1, 16'h5555, 16'hAAAA, 7'd1}},
    '{CMD_POP,   16'h0000, 16'h0000, 1'b1, '{ST_DONE, 16'h5555, 16'hAAAA, 1'b0, 16'h0, 16'h0, 7'd0}}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_wdata = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_command = CMD_PUSH;
  logic [KEY_W-1:0] in_key = '0;
  logic [PLD_W-1:0] in_payload = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_status;
  logic [KEY_W-1:0] out_popped_key;
  logic [PLD_W-1:0] out_popped_payload;
  logic             out_head_valid;
  logic [KEY_W-1:0] out_head_key;
  logic [PLD_W-1:0] out_head_payload;
  logic [6:0]       out_entry_count;

  // travels with the command word: a spelled-out result for directed rows
  logic    word_fixed = 1'b0;
  result_t word_fixed_res = '0;

  // shadow copy of the queue and of the order bit
  logic [KEY_W-1:0] shadow_keys [QUEUE_DEPTH];
  logic [PLD_W-1:0] shadow_payloads [QUEUE_DEPTH];
  int               shadow_count = 0;
  logic             shadow_desc = 1'b0;

  result_t pending_results [$];
  bit      failed = 1'b0;

  // idle rates in percent, and the long receiver hold-off
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  logic     hold_off = 1'b0;
  logic     hold_armed = 1'b0;
  int       hold_left = 0;

  sorted_insert_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_popped_key    (out_popped_key),
    .out_popped_payload(out_popped_payload),
    .out_head_valid    (out_head_valid),
    .out_head_key      (out_head_key),
    .out_head_payload  (out_head_payload),
    .out_entry_count   (out_entry_count)
  );

  always #5 clk = ~clk;

  // true when key a is served strictly ahead of key b under the current order
  function automatic bit serves_ahead(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return shadow_desc ? (a > b) : (a < b);
  endfunction

  // applies one command to the shadow queue and returns the result word it gives
  function automatic result_t apply_command(logic [1:0] cmd, logic [KEY_W-1:0] k,
                                            logic [PLD_W-1:0] p);
    result_t r;
    int      pos;
    int      i;
    r = '0;
    r.status = ST_DONE;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // front only if strictly ahead of the head; ties go behind it
          if (shadow_count == 0 || serves_ahead(k, shadow_keys[0])) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < shadow_count && serves_ahead(shadow_keys[pos], k)) pos++;
          end
          for (i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_payloads[i] = shadow_payloads[i-1];
          end
          shadow_keys[pos] = k;
          shadow_payloads[pos] = p;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_key = shadow_keys[0];
          r.popped_payload = shadow_payloads[0];
          for (i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_payloads[i-1] = shadow_payloads[i];
          end
          shadow_count--;
        end
      end
      CMD_CLEAR: shadow_count = 0;
      default: ;  // unused code leaves everything as it is
    endcase
    if (shadow_count != 0) begin
      r.head_valid = 1'b1;
      r.head_key = shadow_keys[0];
      r.head_payload = shadow_payloads[0];
    end
    r.entry_count = shadow_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // everything seen at one clock edge: order writes, accepted commands, accepted results;
  // a command is predicted before the result check so even a result in the same cycle lines up
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst_n) begin
      if (cfg_we) shadow_desc = cfg_wdata;
      if (in_valid && !in_stall) begin
        want = apply_command(in_command, in_key, in_payload);
        pending_results.push_back(word_fixed ? word_fixed_res : want);
      end
      if (out_valid && !out_stall) begin
        got = '{out_status, out_popped_key, out_popped_payload, out_head_valid,
                out_head_key, out_head_payload, out_entry_count};
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d count %0d",
                 out_status, out_entry_count);
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("popped_key", want.popped_key, got.popped_key);
          check_field("popped_payload", want.popped_payload, got.popped_payload);
          check_field("head_valid", 16'(want.head_valid), 16'(got.head_valid));
          check_field("head_key", want.head_key, got.head_key);
          check_field("head_payload", want.head_payload, got.head_payload);
          check_field("entry_count", 16'(want.entry_count), 16'(got.entry_count));
        end
      end
    end
  end

  // receiver: random stall, plus one long hold-off each time hold_off rises
  always @(posedge clk) begin
    if (hold_off && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    if (!hold_off) hold_armed <= 1'b0;
    out_stall <= (hold_left != 0) || ($urandom_range(99) < snk_idle_pct);
  end

  // offers one command word and returns at the edge that accepts it;
  // always entered right after a rising edge
  task automatic send_word(logic [1:0] cmd, logic [KEY_W-1:0] k, logic [PLD_W-1:0] p,
                           logic fixed, result_t fixed_res);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= k;
    in_payload <= p;
    word_fixed <= fixed;
    word_fixed_res <= fixed_res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // order bit may only change with the block idle
  task automatic write_order(logic desc);
    cfg_we <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop offering and wait for every expected result
  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    for (guard = 0; guard < 20000 && pending_results.size() != 0; guard++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int spread, logic [KEY_W-1:0] base);
    logic [KEY_W-1:0] k;
    case (spread)
      KEYS_NARROW: k = base + KEY_W'($urandom_range(3));  // lots of ties
      KEYS_CORNER: begin
        case ($urandom_range(5))
          0: k = 16'h0000;
          1: k = 16'h0001;
          2: k = 16'h7FFF;
          3: k = 16'h8000;
          4: k = 16'hFFFE;
          default: k = 16'hFFFF;
        endcase
      end
      default: k = KEY_W'($urandom);
    endcase
    return k;
  endfunction

  // random bursts: fill bursts mostly push toward full, drain bursts mostly pop toward
  // empty, mixed bursts push and pop about equally; clear and the unused code are rare
  task automatic run_random(int n_words);
    int               sent;
    int               burst_left;
    int               mode;
    int               spread;
    int               roll;
    logic [KEY_W-1:0] base;
    logic [1:0]       cmd;
    burst_left = 0;
    mode = BURST_MIX;
    spread = KEYS_ANY;
    base = '0;
    for (sent = 0; sent < n_words; sent++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(90, 20);
        mode = $urandom_range(BURST_MIX, BURST_FILL);
        spread = $urandom_range(KEYS_CORNER, KEYS_NARROW);
        base = KEY_W'($urandom);
      end
      burst_left--;
      roll = $urandom_range(99);
      case (mode)
        BURST_FILL:  cmd = roll < 85 ? CMD_PUSH : roll < 97 ? CMD_POP :
                           roll < 99 ? CMD_CLEAR : CMD_UNUSED;
        BURST_DRAIN: cmd = roll < 80 ? CMD_POP : roll < 96 ? CMD_PUSH :
                           roll < 98 ? CMD_CLEAR : CMD_UNUSED;
        default:     cmd = roll < 50 ? CMD_PUSH : roll < 94 ? CMD_POP :
                           roll < 97 ? CMD_CLEAR : CMD_UNUSED;
      endcase
      send_word(cmd, pick_key(spread, base), PLD_W'($urandom), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int row;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ascending order; sender idles rarely, receiver often
    write_order(1'b0);
    src_idle_pct = 8;
    snk_idle_pct = 63;
    for (row = 0; row < DIR_ROWS; row++) begin
      send_word(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].key, DIRECTED_ROWS[row].payload,
                DIRECTED_ROWS[row].fixed, DIRECTED_ROWS[row].res);
    end
    run_random(300);
    settle();

    // descending order; sender idles often, receiver rarely
    write_order(1'b1);
    src_idle_pct = 63;
    snk_idle_pct = 8;
    run_random(300);
    settle();

    // back to ascending with whatever is still queued, no idling at all
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_order(1'b0);
    run_random(150);
    settle();

    // descending; the receiver holds off while pushes keep coming, so the
    // result path backs up into the input, then the queue overfills and
    // drains past empty
    write_order(1'b1);
    hold_off <= 1'b1;
    for (n = 0; n < QUEUE_DEPTH + 6; n++)
      send_word(CMD_PUSH, pick_key(KEYS_NARROW, 16'hFFF8), PLD_W'($urandom), 1'b0, '0);
    for (n = 0; n < QUEUE_DEPTH + 6; n++)
      send_word(CMD_POP, KEY_W'($urandom), PLD_W'($urandom), 1'b0, '0);
    hold_off <= 1'b0;
    run_random(150);
    settle();

    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      failed = 1'b1;
    end
    if (!failed)
      $display("tb_sorted_insert_priority_queue: clean");
    else
      $display("tb_sorted_insert_priority_queue: errors");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_sorted_insert_priority_queue: errors");
    $finish;
  end

endmodule

>>> files.f
design/spiq_pkg.sv
design/spiq_cell.sv
design/sorted_insert_priority_queue.sv
design/spiq_chk.sv
bench/tb_sorted_insert_priority_queue.sv
